FILE: rtl/core/sne_pkg.sv
// Shared types and constants of the spiking network step engine.
package sne_pkg;

    localparam logic [2:0] OP_WR_NODE = 3'd0;
    localparam logic [2:0] OP_WR_SYN  = 3'd1;
    localparam logic [2:0] OP_SET_IN  = 3'd2;
    localparam logic [2:0] OP_STEP    = 3'd3;
    localparam logic [2:0] OP_RD_NODE = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS = 2'd1;
    localparam int CFG_DATA_W = 11;

    localparam logic signed [15:0] Q88_ONE = 16'sd256;
    localparam logic [10:0] FIRED_MAX = 11'd2047;

    typedef struct packed {
        logic [2:0]          op;
        logic [9:0]          nidx;
        logic [12:0]         synapse_index;
        logic [9:0]          source_node;
        logic signed [15:0]  weight;
        logic signed [31:0]  threshold;
        logic signed [31:0]  sum_init;
        logic signed [15:0]  value;
        logic [12:0]         syn_start;
        logic [13:0]         syn_count;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]  rd_value;
        logic signed [15:0]  rd_output;
        logic signed [31:0]  rd_sum;
        logic [10:0]         fired_count;
        logic                bad_index;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_NODE_RD,
        S_NODE_LD,
        S_SYN_RD,
        S_SYN_SRC,
        S_SYN_MUL,
        S_SYN_ACC,
        S_CMP
    } t_state;

endpackage

FILE: rtl/core/sne_if.sv
// Handshake channel interfaces of the spiking network step engine.
interface sne_in_if;
    logic              valid;
    logic              ready;
    sne_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sne_out_if;
    logic               valid;
    logic               ready;
    sne_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sne_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sne_pkg::CFG_IDX_W-1:0]      index;
    logic [sne_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/spiking_network_step_engine.sv
// Top level of the integrate-and-fire spiking network step engine.
// Usage: the host sets num_nodes and num_input_nodes on i_cfg (always ready,
// one beat per cycle), then sends items on i_in: write node, write synapse,
// set input value, run step, read node. Each item returns exactly one beat
// on o_out, held in an output register until taken.
// Write and set-input items stream back to back while o_out is taken; their
// result appears the cycle after acceptance. A read passes through S_READ
// because the node memories have a registered read.
// A step walks the non-input nodes in index order: S_NODE_RD, S_NODE_LD, then
// S_SYN_RD and S_SYN_SRC per synapse, S_SYN_MUL and S_SYN_ACC for one that
// is summed, and S_CMP; one synapse memory read and one value memory read at
// a time through a single registered multiplier. i_in stays low for the whole step.
// Reset clears the control state and both configuration registers; table
// contents are undefined until written, and no clearing pass runs.
// While o_out is stalled, i_in is held low once the current item is done.
module spiking_network_step_engine #(
    parameter int MAX_NODES    = 1024,
    parameter int MAX_SYNAPSES = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sne_in_if.sink        i_in,
    sne_out_if.source     o_out,
    sne_cfg_if.sink       i_cfg
);
    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SAW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int ND_W = 32 + 13 + 14;
    localparam int SO_W = 32 + 16;
    localparam int SY_W = 10 + 16;

    sne_pkg::t_state    r_state, n_state;
    logic [10:0]        r_num_nodes, r_num_inputs;
    logic [NCW-1:0]     r_n;
    logic [13:0]        r_k;
    logic signed [31:0] r_thr, r_acc, r_prod;
    logic [12:0]        r_start;
    logic [13:0]        r_cnt;
    logic signed [15:0] r_wt;
    logic [10:0]        r_fired;
    logic               r_out_valid;
    sne_pkg::t_out_item r_out;

    logic [NCW-1:0]     nn, nin;
    logic               accept, bad;
    sne_pkg::t_in_item  d;

    logic              nd_we, so_we, val_we, sy_we;
    logic [NAW-1:0]    nd_waddr, nd_raddr, so_waddr, so_raddr, val_waddr, val_raddr;
    logic [SAW-1:0]    sy_waddr, sy_raddr;
    logic [ND_W-1:0]   nd_wdata, nd_rdata;
    logic [SO_W-1:0]   so_wdata, so_rdata;
    logic [15:0]       val_wdata, val_rdata;
    logic [SY_W-1:0]   sy_wdata, sy_rdata;

    logic [31:0]        j;
    logic               syn_more, src_ok, fire, last;
    logic signed [32:0] sum33;
    logic signed [31:0] acc_sat;
    logic [10:0]        fired_inc;

    assign d = i_in.data;
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == sne_pkg::S_IDLE) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;

    assign nn  = (32'(r_num_nodes) < MAX_NODES) ? NCW'(r_num_nodes) : NCW'(MAX_NODES);
    assign nin = (32'(r_num_inputs) < 32'(nn)) ? NCW'(r_num_inputs) : nn;

    always_comb begin
        case (d.op)
            sne_pkg::OP_WR_NODE: bad = 32'(d.nidx) >= 32'(nn);
            sne_pkg::OP_WR_SYN:  bad = (32'(d.synapse_index) >= MAX_SYNAPSES)
                                    || (32'(d.source_node) >= MAX_NODES);
            sne_pkg::OP_SET_IN:  bad = 32'(d.nidx) >= 32'(nin);
            sne_pkg::OP_STEP:    bad = 1'b0;
            sne_pkg::OP_RD_NODE: bad = 32'(d.nidx) >= 32'(nn);
            default:             bad = 1'b1;
        endcase
    end

    assign j        = 32'(r_start) + 32'(r_k);
    assign syn_more = (r_k < r_cnt) && (j < MAX_SYNAPSES);
    assign src_ok   = 32'(sy_rdata[SY_W-1:16]) < 32'(nn);
    assign sum33    = {r_acc[31], r_acc} + {r_prod[31], r_prod};
    assign acc_sat  = (sum33[32] != sum33[31])
                    ? (sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sum33[31:0];
    assign fire     = r_acc > r_thr;
    assign last     = 32'(r_n) + 32'd1 >= 32'(nn);
    assign fired_inc = (fire && r_fired != sne_pkg::FIRED_MAX) ? r_fired + 11'd1 : r_fired;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sne_pkg::S_IDLE: begin
                if (accept && !bad) begin
                    if (d.op == sne_pkg::OP_RD_NODE) begin
                        n_state = sne_pkg::S_READ;
                    end else if (d.op == sne_pkg::OP_STEP && nin < nn) begin
                        n_state = sne_pkg::S_NODE_RD;
                    end
                end
            end
            sne_pkg::S_READ:    n_state = sne_pkg::S_IDLE;
            sne_pkg::S_NODE_RD: n_state = sne_pkg::S_NODE_LD;
            sne_pkg::S_NODE_LD: n_state = sne_pkg::S_SYN_RD;
            sne_pkg::S_SYN_RD:  n_state = syn_more ? sne_pkg::S_SYN_SRC : sne_pkg::S_CMP;
            sne_pkg::S_SYN_SRC: n_state = src_ok ? sne_pkg::S_SYN_MUL : sne_pkg::S_SYN_RD;
            sne_pkg::S_SYN_MUL: n_state = sne_pkg::S_SYN_ACC;
            sne_pkg::S_SYN_ACC: n_state = sne_pkg::S_SYN_RD;
            sne_pkg::S_CMP:     n_state = last ? sne_pkg::S_IDLE : sne_pkg::S_NODE_RD;
            default:            n_state = sne_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        nd_we = 1'b0; so_we = 1'b0; val_we = 1'b0; sy_we = 1'b0;
        nd_waddr  = NAW'(32'(d.nidx));
        nd_wdata  = {d.threshold, d.syn_start, d.syn_count};
        nd_raddr  = r_n[NAW-1:0];
        so_waddr  = NAW'(32'(d.nidx));
        so_wdata  = {d.sum_init, d.value};
        so_raddr  = r_n[NAW-1:0];
        val_waddr = NAW'(32'(d.nidx));
        val_wdata = d.value;
        val_raddr = NAW'(32'(d.nidx));
        sy_waddr  = SAW'(32'(d.synapse_index));
        sy_wdata  = {d.source_node, d.weight};
        sy_raddr  = j[SAW-1:0];
        case (r_state)
            sne_pkg::S_IDLE: begin
                so_raddr = NAW'(32'(d.nidx));
                if (accept && !bad) begin
                    case (d.op)
                        sne_pkg::OP_WR_NODE: begin
                            nd_we = 1'b1; so_we = 1'b1; val_we = 1'b1;
                        end
                        sne_pkg::OP_WR_SYN: sy_we = 1'b1;
                        sne_pkg::OP_SET_IN: val_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            sne_pkg::S_NODE_LD: begin
                val_we    = 1'b1;
                val_waddr = r_n[NAW-1:0];
                val_wdata = so_rdata[15:0];
            end
            sne_pkg::S_SYN_SRC: val_raddr = NAW'(32'(sy_rdata[SY_W-1:16]));
            sne_pkg::S_CMP: begin
                so_we    = 1'b1;
                so_waddr = r_n[NAW-1:0];
                so_wdata = fire ? {32'sd0, sne_pkg::Q88_ONE} : {r_acc, 16'sd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sne_pkg::S_IDLE;
            r_num_nodes  <= '0;
            r_num_inputs <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    sne_pkg::CFG_NUM_NODES:  r_num_nodes  <= i_cfg.data;
                    sne_pkg::CFG_NUM_INPUTS: r_num_inputs <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((accept && (bad || (d.op != sne_pkg::OP_RD_NODE
                    && !(d.op == sne_pkg::OP_STEP && nin < nn))))
                || r_state == sne_pkg::S_READ
                || (r_state == sne_pkg::S_CMP && last)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sne_pkg::S_IDLE: begin
                r_n     <= nin;
                r_fired <= '0;
                if (accept) begin
                    r_out <= '{rd_value: '0, rd_output: '0, rd_sum: '0,
                               fired_count: '0, bad_index: bad};
                end
            end
            sne_pkg::S_READ: begin
                r_out.rd_value  <= val_rdata;
                r_out.rd_output <= so_rdata[15:0];
                r_out.rd_sum    <= so_rdata[SO_W-1:16];
            end
            sne_pkg::S_NODE_LD: begin
                r_thr   <= nd_rdata[ND_W-1:27];
                r_start <= nd_rdata[26:14];
                r_cnt   <= nd_rdata[13:0];
                r_acc   <= so_rdata[SO_W-1:16];
                r_k     <= '0;
            end
            sne_pkg::S_SYN_SRC: begin
                r_wt <= sy_rdata[15:0];
                if (!src_ok) begin
                    r_k <= r_k + 14'd1;
                end
            end
            sne_pkg::S_SYN_MUL: r_prod <= $signed(val_rdata) * r_wt;
            sne_pkg::S_SYN_ACC: begin
                r_acc <= acc_sat;
                r_k   <= r_k + 14'd1;
            end
            sne_pkg::S_CMP: begin
                r_fired           <= fired_inc;
                r_n               <= r_n + NCW'(1);
                r_out.fired_count <= fired_inc;
            end
            default: ;
        endcase
    end

    sne_ram #(.WIDTH(ND_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );

    sne_ram #(.WIDTH(SO_W), .DEPTH(MAX_NODES)) u_sum_ram (
        .i_clk(i_clk), .i_we(so_we), .i_waddr(so_waddr), .i_wdata(so_wdata),
        .i_raddr(so_raddr), .o_rdata(so_rdata)
    );

    sne_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_value_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_raddr(val_raddr), .o_rdata(val_rdata)
    );

    sne_ram #(.WIDTH(SY_W), .DEPTH(MAX_SYNAPSES)) u_syn_ram (
        .i_clk(i_clk), .i_we(sy_we), .i_waddr(sy_waddr), .i_wdata(sy_wdata),
        .i_raddr(sy_raddr), .o_rdata(sy_rdata)
    );

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == sne_pkg::S_IDLE)
        else $error("input ready outside idle");
    a_syn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sne_pkg::S_SYN_SRC |-> r_k < r_cnt)
        else $error("synapse walk past node count");
    a_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sne_pkg::S_CMP && last) |=> o_out.valid)
        else $error("step result missing");
    a_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sne_pkg::S_NODE_RD |-> r_n < nn)
        else $error("step node beyond nodes in use");
`endif
endmodule

FILE: rtl/core/sne_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module sne_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
